// ===== sv/glushkov_nfa_reverse_scanner_unit_macros.svh =====
`ifndef GLUSHKOV_NFA_REVERSE_SCANNER_UNIT_MACROS_SVH
`define GLUSHKOV_NFA_REVERSE_SCANNER_UNIT_MACROS_SVH

// check a property once reset is released
`define GNRS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("gnrs assertion failed");

// check a property at every edge, reset included
`define GNRS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("gnrs assertion failed");

`endif

// ===== sv/gnrs_pkg.sv =====
`timescale 1ns / 1ps

package gnrs_pkg;

  localparam int unsigned MASK_W         = 32;
  localparam int unsigned BYTE_W         = 8;
  localparam int unsigned IDX_W          = 8;
  localparam int unsigned CFG_IDX_W      = 1;
  localparam int unsigned NUM_STATES_DEF = 32;
  localparam int unsigned CHAR_DEPTH     = 1 << BYTE_W;

  localparam logic [MASK_W-1:0] NFA_INIT_STATE = MASK_W'(1);

  typedef enum logic [1:0] {
    MODE_FOLLOW = 2'd0,
    MODE_CHAR   = 2'd1,
    MODE_START  = 2'd2,
    MODE_BYTE   = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MATCH_MASK = 1'b0,
    CFG_ANCHORED   = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [BYTE_W-1:0] waddr;
    logic [BYTE_W-1:0] raddr;
    logic [MASK_W-1:0] wdata;
  } mem_req_t;

endpackage

// ===== sv/gnrs_char_mem.sv =====
`timescale 1ns / 1ps

module gnrs_char_mem (
  input  logic                              clk_i,
  input  gnrs_pkg::mem_req_t                req_i,
  output logic [gnrs_pkg::MASK_W-1:0]       rdata_o
);

  logic [gnrs_pkg::MASK_W-1:0] mem_q [gnrs_pkg::CHAR_DEPTH];
  logic [gnrs_pkg::MASK_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/glushkov_nfa_reverse_scanner_unit.sv =====
// Reverse bit-parallel NFA scanner.
// Input channel (in_valid_i / in_stall_o) carries one transaction per item:
// follower table write, character table write, search start, or a search
// byte given in reverse order. Table writes land at the accepting edge and
// affect every later transaction.
// Output channel (out_valid_o / out_stall_i) carries one result per scan:
// match_found_o and match_offset_o (zero when nothing was found).
// The transaction that ends a scan is registered in the input stage, and
// its result then in the output register. Throughput: one transaction per
// cycle while in_stall_o is low; the character mask is read from its
// memory at the accepting edge so the state update is a single OR/AND
// stage between the input stage and the state and output registers.
// The user must write config (cfg_we_i, cfg_idx_i, cfg_wdata_i) only while
// idle, unenforced. Reset: no scan is active, state vector is the
// starting state, output is empty; tables are undefined until loaded.
// When out_stall_i holds a result, transactions are still taken into the
// input stage; in_stall_o rises once the one held there ends a scan too.
`timescale 1ns / 1ps

module glushkov_nfa_reverse_scanner_unit #(
  parameter int unsigned NUM_STATES = gnrs_pkg::NUM_STATES_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [gnrs_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [gnrs_pkg::MASK_W-1:0]        cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [1:0]                         mode_i,
  input  logic [gnrs_pkg::IDX_W-1:0]         table_index_i,
  input  logic [gnrs_pkg::MASK_W-1:0]        mask_value_i,
  input  logic [gnrs_pkg::BYTE_W-1:0]        byte_value_i,
  input  logic                               is_last_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               match_found_o,
  output logic [gnrs_pkg::MASK_W-1:0]        match_offset_o
);

  localparam int unsigned MW     = gnrs_pkg::MASK_W;
  localparam int unsigned FIDX_W = $clog2(NUM_STATES);
  localparam int unsigned NLIVE  = (NUM_STATES < MW) ? NUM_STATES : MW;

  logic                  accept;
  gnrs_pkg::mode_e       in_mode;
  gnrs_pkg::mem_req_t    mem_req;
  logic [MW-1:0]         char_rd;

  logic [MW-1:0]         follower_q [NUM_STATES];

  logic [MW-1:0]         match_mask_q;
  logic                  anchored_q;

  logic                  s1_valid_q, s1_valid_d;
  gnrs_pkg::mode_e       s1_mode_q;
  logic                  s1_last_q;
  logic                  s1_fire;

  logic [MW-1:0]         nfa_q, nfa_d;
  logic [MW-1:0]         bytes_q, bytes_d;
  logic [MW-1:0]         best_off_q, best_off_d;
  logic                  best_v_q, best_v_d;
  logic                  done_q, done_d;

  logic [MW-1:0]         follow_acc;
  logic [MW-1:0]         step_state;
  logic [MW-1:0]         bytes_inc;
  logic                  emit;
  logic                  emit_found;
  logic [MW-1:0]         emit_off;

  logic                  out_ready;
  logic                  out_valid_q, out_valid_d;
  logic                  found_q;
  logic [MW-1:0]         offset_q;

  assign in_mode    = gnrs_pkg::mode_e'(mode_i);
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && emit && !out_ready;
  assign accept     = in_valid_i && !in_stall_o;
  assign s1_fire    = s1_valid_q && (!emit || out_ready);

  // character table, read ahead at the accepting edge
  always_comb begin
    mem_req.we    = accept && (in_mode == gnrs_pkg::MODE_CHAR);
    mem_req.waddr = table_index_i;
    mem_req.wdata = mask_value_i;
    mem_req.re    = accept;
    mem_req.raddr = byte_value_i;
  end

  gnrs_char_mem u_char_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (char_rd)
  );

  always_ff @(posedge clk_i) begin
    if (accept && (in_mode == gnrs_pkg::MODE_FOLLOW) &&
        (32'(table_index_i) < NUM_STATES)) begin
      follower_q[table_index_i[FIDX_W-1:0]] <= mask_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_mask_q <= '0;
      anchored_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (gnrs_pkg::cfg_idx_e'(cfg_idx_i))
        gnrs_pkg::CFG_MATCH_MASK: match_mask_q <= cfg_wdata_i;
        gnrs_pkg::CFG_ANCHORED:   anchored_q   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // follower union of every active state, masked by the byte
  always_comb begin
    follow_acc = '0;
    for (int i = 0; i < NLIVE; i++) begin
      if (nfa_q[i]) begin
        follow_acc = follow_acc | follower_q[i];
      end
    end
    step_state = follow_acc & char_rd;
  end

  assign bytes_inc = (bytes_q == '1) ? bytes_q : bytes_q + 1'b1;

  always_comb begin
    nfa_d      = nfa_q;
    bytes_d    = bytes_q;
    best_off_d = best_off_q;
    best_v_d   = best_v_q;
    done_d     = done_q;
    emit       = 1'b0;
    emit_found = 1'b0;
    emit_off   = '0;
    case (s1_mode_q)
      gnrs_pkg::MODE_START: begin
        nfa_d      = gnrs_pkg::NFA_INIT_STATE;
        bytes_d    = '0;
        best_off_d = '0;
        best_v_d   = 1'b0;
        done_d     = 1'b0;
        if (s1_last_q) begin
          emit       = 1'b1;
          emit_found = |(gnrs_pkg::NFA_INIT_STATE & match_mask_q);
          done_d     = 1'b1;
        end
      end
      gnrs_pkg::MODE_BYTE: begin
        if (!done_q) begin
          if (!anchored_q && (|(nfa_q & match_mask_q))) begin
            best_off_d = bytes_q;
            best_v_d   = 1'b1;
          end
          nfa_d   = step_state;
          bytes_d = bytes_inc;
          if (s1_last_q && (|(step_state & match_mask_q))) begin
            emit       = 1'b1;
            emit_found = 1'b1;
            emit_off   = bytes_inc;
          end else if (s1_last_q || (step_state == '0)) begin
            emit       = 1'b1;
            emit_found = best_v_d;
            emit_off   = best_v_d ? best_off_d : '0;
          end
          if (emit) begin
            done_d = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  assign s1_valid_d = accept ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_q);

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_fire && emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      nfa_q       <= gnrs_pkg::NFA_INIT_STATE;
      bytes_q     <= '0;
      best_off_q  <= '0;
      best_v_q    <= 1'b0;
      done_q      <= 1'b1;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_fire) begin
        nfa_q      <= nfa_d;
        bytes_q    <= bytes_d;
        best_off_q <= best_off_d;
        best_v_q   <= best_v_d;
        done_q     <= done_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_mode_q <= in_mode;
      s1_last_q <= is_last_i;
    end
    if (s1_fire && emit) begin
      found_q  <= emit_found;
      offset_q <= emit_off;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign match_found_o  = found_q;
  assign match_offset_o = offset_q;

endmodule

// ===== sv/gnrs_checker.sv =====
`timescale 1ns / 1ps
`include "glushkov_nfa_reverse_scanner_unit_macros.svh"

module gnrs_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic                          match_found_o,
  input logic [gnrs_pkg::MASK_W-1:0]   match_offset_o
);

  // a held result keeps its payload
  `GNRS_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(match_found_o) && $stable(match_offset_o))

  // no match means a zero offset
  `GNRS_ASSERT(a_nomatch_zero, clk_i, rst_ni, out_valid_o && !match_found_o |-> match_offset_o == '0)

  // input backpressure only while a result is held
  `GNRS_ASSERT(a_stall_cause, clk_i, rst_ni, in_stall_o |-> out_valid_o && out_stall_i)

  // quiet channels during reset
  `GNRS_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> !out_valid_o && !in_stall_o)

endmodule

bind glushkov_nfa_reverse_scanner_unit gnrs_checker u_gnrs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .match_found_o  (match_found_o),
  .match_offset_o (match_offset_o)
);
